### hw/rtl/lav_pkg.sv
package lav_pkg;

  // wide signed intermediate and q2.30 / q16.16 component types
  typedef logic signed [63:0] wide_t;
  typedef logic signed [31:0] q30_t;

  // normalize unit: 32-bit root and 31-bit quotient, two bits per stage (one in the last divide stage)
  localparam int ROOT_BITS  = 32;
  localparam int QUO_BITS   = 31;
  localparam int SQ_STAGES  = ROOT_BITS / 2;
  localparam int DIV_STAGES = (QUO_BITS + 1) / 2;
  // abs, lead, shift, square, sum, root stages, numerator, divide stages, output
  localparam int NORM_LAT   = 5 + SQ_STAGES + 1 + DIV_STAGES + 1;

endpackage

### hw/rtl/look_at_view_matrix_core.sv
// Left-handed look-at basis: from eye, target and up hint (Q16.16) each item yields
// right, true up and look (Q2.30) plus the three negated eye dot products (Q16.16,
// saturated). One item is accepted per clock unless the output stalls, and results
// leave in order; the depth is set by the two normalize units, each running a
// 16-stage square root and a 16-stage divider at up to two bits per stage. A zero-length
// vector normalizes to zero. Backpressure stalls the whole pipeline at once.
module look_at_view_matrix_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_hint_x, up_hint_y, up_hint_z
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // right_x, right_y, right_z, true_up_x, true_up_y, true_up_z, look_x, look_y, look_z,
  // neg_eye_dot_right, neg_eye_dot_up, neg_eye_dot_look
  output logic [383:0] out_tdata
);

  localparam int NL  = lav_pkg::NORM_LAT;
  localparam int TOT = 2 * NL + 7;

  function automatic lav_pkg::q30_t sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  logic [TOT-1:0]  vld_r;
  logic            en;

  lav_pkg::q30_t   eye_a_r  [3];
  lav_pkg::q30_t   up_a_r   [3];
  logic signed [32:0] dir_a_r [3];
  lav_pkg::wide_t  dir_w    [3];
  lav_pkg::q30_t   look_w   [3];
  lav_pkg::q30_t   eye_d1_r [NL][3];
  lav_pkg::q30_t   up_d1_r  [NL][3];

  lav_pkg::wide_t  cpa_r [3];
  lav_pkg::wide_t  cpb_r [3];
  lav_pkg::q30_t   eye_c1_r  [3];
  lav_pkg::q30_t   look_c1_r [3];
  lav_pkg::wide_t  rc_c2_r   [3];
  lav_pkg::q30_t   eye_c2_r  [3];
  lav_pkg::q30_t   look_c2_r [3];
  lav_pkg::q30_t   right_w   [3];
  lav_pkg::q30_t   eye_d2_r  [NL][3];
  lav_pkg::q30_t   look_d2_r [NL][3];

  lav_pkg::wide_t  upa_r [3];
  lav_pkg::wide_t  upb_r [3];
  lav_pkg::q30_t   eye_u1_r   [3];
  lav_pkg::q30_t   look_u1_r  [3];
  lav_pkg::q30_t   right_u1_r [3];
  lav_pkg::q30_t   tup_u2_r   [3];
  lav_pkg::q30_t   eye_u2_r   [3];
  lav_pkg::q30_t   look_u2_r  [3];
  lav_pkg::q30_t   right_u2_r [3];

  lav_pkg::wide_t  dp_r [3][3];
  lav_pkg::q30_t   bas_d1_r [9];
  logic [383:0]    out_data_r;

  logic signed [65:0] uc_v  [3];
  logic signed [65:0] dot_v [3];

  // global advance: the pipeline moves unless the output item is stalled
  assign en         = !vld_r[TOT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[TOT-1];
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT-2:0], in_tvalid};
    end
  end

  // input stage: direction = target - eye
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye_a_r[i] <= $signed(in_tdata[32*i +: 32]);
        up_a_r[i]  <= $signed(in_tdata[32*(i+6) +: 32]);
        dir_a_r[i] <= $signed({in_tdata[32*(i+3)+31], in_tdata[32*(i+3) +: 32]})
                    - $signed({in_tdata[32*i+31], in_tdata[32*i +: 32]});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_w[i] = {{31{dir_a_r[i][32]}}, dir_a_r[i]};
    end
  end

  lav_norm u_norm_look (
    .clk   (clk),
    .en    (en),
    .vec_i (dir_w),
    .vec_o (look_w)
  );

  // eye and up hint ride alongside the look normalize
  always_ff @(posedge clk) begin
    if (en) begin
      eye_d1_r[0] <= eye_a_r;
      up_d1_r[0]  <= up_a_r;
      for (int j = 1; j < NL; j++) begin
        eye_d1_r[j] <= eye_d1_r[j-1];
        up_d1_r[j]  <= up_d1_r[j-1];
      end
    end
  end

  // up hint x look: products, then differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cpa_r[i] <= lav_pkg::wide_t'(up_d1_r[NL-1][(i+1)%3]) *
                    lav_pkg::wide_t'(look_w[(i+2)%3]);
        cpb_r[i] <= lav_pkg::wide_t'(up_d1_r[NL-1][(i+2)%3]) *
                    lav_pkg::wide_t'(look_w[(i+1)%3]);
        rc_c2_r[i] <= cpa_r[i] - cpb_r[i];
      end
      eye_c1_r  <= eye_d1_r[NL-1];
      look_c1_r <= look_w;
      eye_c2_r  <= eye_c1_r;
      look_c2_r <= look_c1_r;
    end
  end

  lav_norm u_norm_right (
    .clk   (clk),
    .en    (en),
    .vec_i (rc_c2_r),
    .vec_o (right_w)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      eye_d2_r[0]  <= eye_c2_r;
      look_d2_r[0] <= look_c2_r;
      for (int j = 1; j < NL; j++) begin
        eye_d2_r[j]  <= eye_d2_r[j-1];
        look_d2_r[j] <= look_d2_r[j-1];
      end
    end
  end

  // look x right, rounded from q4.60 to q2.30
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uc_v[i] = (66'(upa_r[i]) - 66'(upb_r[i]) + 66'sd536870912) >>> 30;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        upa_r[i] <= lav_pkg::wide_t'(look_d2_r[NL-1][(i+1)%3]) *
                    lav_pkg::wide_t'(right_w[(i+2)%3]);
        upb_r[i] <= lav_pkg::wide_t'(look_d2_r[NL-1][(i+2)%3]) *
                    lav_pkg::wide_t'(right_w[(i+1)%3]);
        tup_u2_r[i] <= sat32(uc_v[i]);
      end
      eye_u1_r   <= eye_d2_r[NL-1];
      look_u1_r  <= look_d2_r[NL-1];
      right_u1_r <= right_w;
      eye_u2_r   <= eye_u1_r;
      look_u2_r  <= look_u1_r;
      right_u2_r <= right_u1_r;
    end
  end

  // eye dot products: per-term products, then rounded negated sums
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      dot_v[b] = -((66'(dp_r[b][0]) + 66'(dp_r[b][1]) + 66'(dp_r[b][2])
                   + 66'sd536870912) >>> 30);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[0][i]     <= lav_pkg::wide_t'(eye_u2_r[i]) * lav_pkg::wide_t'(right_u2_r[i]);
        dp_r[1][i]     <= lav_pkg::wide_t'(eye_u2_r[i]) * lav_pkg::wide_t'(tup_u2_r[i]);
        dp_r[2][i]     <= lav_pkg::wide_t'(eye_u2_r[i]) * lav_pkg::wide_t'(look_u2_r[i]);
        bas_d1_r[i]    <= right_u2_r[i];
        bas_d1_r[i+3]  <= tup_u2_r[i];
        bas_d1_r[i+6]  <= look_u2_r[i];
      end
      for (int i = 0; i < 9; i++) begin
        out_data_r[32*i +: 32] <= bas_d1_r[i];
      end
      for (int b = 0; b < 3; b++) begin
        out_data_r[32*(b+9) +: 32] <= sat32(dot_v[b]);
      end
    end
  end

  // unit vectors never exceed one in q2.30
  a_look_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[223:192]) <= 32'sd1073741824 &&
                    $signed(out_tdata[223:192]) >= -32'sd1073741824))
    else $error("look_x outside unit range");

  a_right_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[31:0]) <= 32'sd1073741824 &&
                    $signed(out_tdata[31:0]) >= -32'sd1073741824))
    else $error("right_x outside unit range");

  // an accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted item lost at pipeline entry");

endmodule

### hw/rtl/lav_norm.sv
module lav_norm (
  input  logic           clk,
  input  logic           en,
  input  lav_pkg::wide_t vec_i [3],
  output lav_pkg::q30_t  vec_o [3]
);

  localparam int SQ = lav_pkg::SQ_STAGES;
  localparam int DV = lav_pkg::DIV_STAGES;
  localparam int RB = lav_pkg::ROOT_BITS;
  localparam int QB = lav_pkg::QUO_BITS;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  typedef struct packed {
    logic [61:0] rem;
    logic [30:0] quo;
  } dv_t;

  // one bit of the square root: rem holds s - root^2
  function automatic sq_t sqrt_bit(input sq_t s, input int b);
    sq_t         r;
    logic [65:0] t;
    r = s;
    t = ({34'd0, s.root} << (b + 1)) + (66'd1 << (2 * b));
    if ({2'b00, s.rem} >= t) begin
      r.rem  = s.rem - t[63:0];
      r.root = s.root | (32'd1 << b);
    end
    return r;
  endfunction

  // one restoring divide bit
  function automatic dv_t div_bit(input dv_t s, input logic [31:0] len, input int b);
    dv_t         r;
    logic [63:0] t;
    r = s;
    t = {32'd0, len} << b;
    if ({2'b00, s.rem} >= t) begin
      r.rem = s.rem - t[61:0];
      r.quo = s.quo | (31'd1 << b);
    end
    return r;
  endfunction

  function automatic dv_t div_pair(input dv_t s, input logic [31:0] len, input int hi);
    dv_t r;
    r = div_bit(s, len, hi);
    if (hi - 1 >= 0) begin
      r = div_bit(r, len, hi - 1);
    end
    return r;
  endfunction

  logic        neg0_r [3];
  logic [62:0] mag0_r [3];
  logic [62:0] max0_r;
  logic        neg1_r [3];
  logic [62:0] mag1_r [3];
  logic [5:0]  lead1_r;
  logic        zero1_r;
  logic        neg2_r [3];
  logic [30:0] ms2_r  [3];
  logic        zero2_r;
  logic        neg3_r [3];
  logic [30:0] ms3_r  [3];
  logic [61:0] sq3_r  [3];
  logic        zero3_r;

  sq_t         sq_r    [0:SQ];
  logic        sneg_r  [0:SQ][3];
  logic [30:0] sms_r   [0:SQ][3];
  logic        szero_r [0:SQ];

  dv_t         dv_r    [0:DV][3];
  logic [31:0] dlen_r  [0:DV];
  logic        dneg_r  [0:DV][3];
  logic        dzero_r [0:DV];

  logic        neg0_nxt [3];
  logic [62:0] mag0_nxt [3];
  logic [62:0] max0_nxt;
  logic [63:0] abs_v    [3];
  logic [5:0]  lead1_nxt;
  logic [62:0] shf_v    [3];
  lav_pkg::q30_t vec_r  [3];

  // magnitudes and the largest one
  always_comb begin
    max0_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      neg0_nxt[i] = vec_i[i][63];
      abs_v[i]    = vec_i[i][63] ? 64'(-vec_i[i]) : 64'(vec_i[i]);
      mag0_nxt[i] = abs_v[i][62:0];
      if (mag0_nxt[i] > max0_nxt) begin
        max0_nxt = mag0_nxt[i];
      end
    end
  end

  // leading one of the largest magnitude
  always_comb begin
    lead1_nxt = '0;
    for (int i = 0; i < 63; i++) begin
      if (max0_r[i]) begin
        lead1_nxt = 6'(i);
      end
    end
  end

  // common shift so the largest lands in [2^30, 2^31)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead1_r >= 6'd30) begin
        shf_v[i] = mag1_r[i] >> (lead1_r - 6'd30);
      end else begin
        shf_v[i] = mag1_r[i] << (6'd30 - lead1_r);
      end
    end
  end

  // front stages: abs, lead, shift, square, sum
  always_ff @(posedge clk) begin
    if (en) begin
      neg0_r   <= neg0_nxt;
      mag0_r   <= mag0_nxt;
      max0_r   <= max0_nxt;
      neg1_r   <= neg0_r;
      mag1_r   <= mag0_r;
      lead1_r  <= lead1_nxt;
      zero1_r  <= (max0_r == '0);
      neg2_r   <= neg1_r;
      zero2_r  <= zero1_r;
      neg3_r   <= neg2_r;
      ms3_r    <= ms2_r;
      zero3_r  <= zero2_r;
      for (int i = 0; i < 3; i++) begin
        ms2_r[i] <= shf_v[i][30:0];
        sq3_r[i] <= 62'(ms2_r[i]) * 62'(ms2_r[i]);
      end
      sq_r[0].rem  <= 64'(sq3_r[0]) + 64'(sq3_r[1]) + 64'(sq3_r[2]);
      sq_r[0].root <= '0;
      sneg_r[0]    <= neg3_r;
      sms_r[0]     <= ms3_r;
      szero_r[0]   <= zero3_r;
    end
  end

  // square root pipeline, two bits per stage
  for (genvar k = 1; k <= SQ; k++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]    <= sqrt_bit(sqrt_bit(sq_r[k-1], RB + 1 - 2 * k), RB - 2 * k);
        sneg_r[k]  <= sneg_r[k-1];
        sms_r[k]   <= sms_r[k-1];
        szero_r[k] <= szero_r[k-1];
      end
    end
  end

  // numerator m * 2^30 + floor(len / 2)
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_r[0][i].rem <= {sms_r[SQ][i], 30'd0} + 62'(sq_r[SQ].root >> 1);
        dv_r[0][i].quo <= '0;
      end
      dlen_r[0]  <= sq_r[SQ].root;
      dneg_r[0]  <= sneg_r[SQ];
      dzero_r[0] <= szero_r[SQ];
    end
  end

  // divider pipeline, two quotient bits per stage (one in the last)
  for (genvar k = 1; k <= DV; k++) begin : g_dv
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_r[k][i] <= div_pair(dv_r[k-1][i], dlen_r[k-1], QB + 1 - 2 * k);
        end
        dlen_r[k]  <= dlen_r[k-1];
        dneg_r[k]  <= dneg_r[k-1];
        dzero_r[k] <= dzero_r[k-1];
      end
    end
  end

  // sign and zero-length handling
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dzero_r[DV]) begin
          vec_r[i] <= '0;
        end else if (dneg_r[DV][i]) begin
          vec_r[i] <= -$signed({1'b0, dv_r[DV][i].quo});
        end else begin
          vec_r[i] <= $signed({1'b0, dv_r[DV][i].quo});
        end
      end
    end
  end

  assign vec_o = vec_r;

endmodule
